### sv/timdec_pkg.sv
// ============================================================================
// timdec_pkg: shared types and constants of the TIM image stream decoder
// Parser phases, queue record layout, result layout and color conversion.
// ============================================================================
package timdec_pkg;

    localparam logic [31:0] MAGIC_WORD    = 32'h0000_0010;
    localparam logic [7:0]  TYPE_4BPP     = 8'(1 << 3);
    localparam logic [7:0]  TYPE_8BPP     = 8'((1 << 3) | 1);
    localparam logic [7:0]  TYPE_15BPP    = 8'h02;
    localparam logic [11:0] MAX_ROW_WIDTH = 12'd4095;
    localparam logic [33:0] PAL_HDR_BYTES = 34'd12;

    // byte positions inside a 12-byte block header
    localparam logic [3:0]  WORD_END      = 4'd3;
    localparam logic [3:0]  HDR_RSV_END   = 4'd7;
    localparam logic [3:0]  HDR_LO_END    = 4'd9;
    localparam logic [3:0]  HDR_HI_END    = 4'd11;

    localparam logic [1:0]  ERR_MAGIC     = 2'd0;
    localparam logic [1:0]  ERR_TYPE      = 2'd1;
    localparam logic [1:0]  ERR_OVERRUN   = 2'd2;
    localparam logic [1:0]  ERR_TRUNC     = 2'd3;
    localparam logic [1:0]  CODE_NONE     = 2'd0;

    localparam logic        CFG_FORCED_WIDTH  = 1'b0;
    localparam logic        CFG_FORCED_HEIGHT = 1'b1;

    localparam int          FIFO_DEPTH    = 4;
    localparam int          FIFO_AW       = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_TYPE,
        PH_PALHDR,
        PH_PALCHK,
        PH_PALDATA,
        PH_PALSKIP,
        PH_PIXHDR,
        PH_PIXDATA,
        PH_IDLE
    } t_phase;

    typedef enum logic [2:0] {
        K_PAL,
        K_INDEX,
        K_COLOR,
        K_ERROR,
        K_DONE
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PAL,
        OP_NIB1,
        OP_NIB2,
        OP_IDX8,
        OP_COLOR
    } t_op;

    typedef enum logic [1:0] {
        TL_NONE,
        TL_DONE,
        TL_ERROR
    } t_tail;

    // one classified input byte
    typedef struct packed {
        t_op         op;
        t_tail       tail;
        logic [1:0]  code;
        logic [15:0] data;
        logic [11:0] x;
        logic [15:0] y;
    } t_rec;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [11:0] x;
        logic [15:0] y;
        logic [1:0]  code;
    } t_result;

    function automatic logic [15:0] abgr_to_rgba(input logic [15:0] c);
        logic a;
        a = c[15] | (|c[14:0]);
        return {c[4:0], c[9:5], c[14:10], a};
    endfunction

    function automatic logic [1:0] rec_count(input t_rec r);
        logic [1:0] m;
        case (r.op)
            OP_NONE: m = 2'd0;
            OP_NIB2: m = 2'd2;
            default: m = 2'd1;
        endcase
        return m + ((r.tail != TL_NONE) ? 2'd1 : 2'd0);
    endfunction

endpackage

### sv/timdec_front.sv
// ============================================================================
// timdec_front: TIM file parser
// Accepts one byte per transaction, tracks the file structure and classifies
// each byte into a record of the results it causes.
// ============================================================================
module timdec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    input  logic [11:0]       i_forced_width,
    input  logic [8:0]        i_forced_height,
    input  logic              i_full,
    output logic              o_push,
    output timdec_pkg::t_rec  o_rec
);
    import timdec_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_ent, n_ent;
    logic [15:0] r_sets, n_sets;
    logic [15:0] r_ent_ctr, n_ent_ctr;
    logic [15:0] r_set_ctr, n_set_ctr;
    logic [31:0] r_skip, n_skip;
    logic [11:0] r_row_width, n_row_width;
    logic [15:0] r_row_count, n_row_count;
    logic [11:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [7:0]  r_low, n_low;
    logic [31:0] r_prod, n_prod;
    logic        r_eos_hold, n_eos_hold;
    logic        r_held_pend, n_held_pend;

    logic        w_accept, w_step, w_eos, w_defer;
    logic [31:0] w_sh;
    logic [33:0] w_need;
    logic        w_over;
    logic [31:0] w_skip_left;
    logic        w_type4, w_type8;
    logic [12:0] w_c1, w_c2, w_col_new;
    logic        w_nib2, w_wrap, w_img_end, w_pix_emit;
    logic [15:0] w_row_new;
    logic [16:0] w_ent_inc, w_set_inc;
    logic [17:0] w_hw;
    logic [11:0] w_rw_new;
    logic [15:0] w_rc_new;

    // datapath helpers
    always_comb begin
        w_sh        = r_shift | (32'(i_byte) << {r_cnt[1:0], 3'b000});
        w_need      = PAL_HDR_BYTES + {1'b0, r_prod, 1'b0};
        w_over      = w_need > {2'b00, r_skip};
        w_skip_left = r_skip - w_need[31:0];
        w_type4     = (r_type == TYPE_4BPP);
        w_type8     = (r_type == TYPE_8BPP);
        w_c1        = {1'b0, r_col} + 13'd1;
        w_c2        = {1'b0, r_col} + 13'd2;
        w_nib2      = w_type4 && (w_c1 < {1'b0, r_row_width});
        w_col_new   = w_nib2 ? w_c2 : w_c1;
        w_wrap      = w_col_new >= {1'b0, r_row_width};
        w_row_new   = r_row + 16'd1;
        w_img_end   = w_wrap && (w_row_new >= r_row_count);
        w_pix_emit  = w_type4 || w_type8 || r_cnt[0];
        w_ent_inc   = {1'b0, r_ent_ctr} + 17'd1;
        w_set_inc   = {1'b0, r_set_ctr} + 17'd1;
        case (r_type)
            TYPE_4BPP: w_hw = {w_sh[15:0], 2'b00};
            TYPE_8BPP: w_hw = {1'b0, w_sh[15:0], 1'b0};
            default:   w_hw = {2'b00, w_sh[15:0]};
        endcase
        w_rw_new = (w_hw > 18'(MAX_ROW_WIDTH)) ? MAX_ROW_WIDTH : w_hw[11:0];
        if (i_forced_width != '0) begin
            w_rw_new = i_forced_width;
        end
        w_rc_new = (i_forced_height != '0) ? {7'b0, i_forced_height} : w_sh[31:16];
    end

    // outputs: handshake and classified record
    always_comb begin
        o_ready  = (r_phase != PH_PALCHK) && !i_full;
        w_accept = i_valid && o_ready;
        w_step   = 1'b0;
        w_eos    = 1'b0;
        w_defer  = 1'b0;
        o_rec.op   = OP_NONE;
        o_rec.tail = TL_NONE;
        o_rec.code = CODE_NONE;
        o_rec.data = {8'b0, i_byte};
        o_rec.x    = r_col;
        o_rec.y    = r_row;
        if (r_phase == PH_PALCHK) begin
            w_step = !i_full;
            w_eos  = r_eos_hold;
            if (w_over) begin
                o_rec.tail = TL_ERROR;
                o_rec.code = ERR_OVERRUN;
            end
        end else if (w_accept) begin
            w_step = 1'b1;
            w_eos  = i_eos;
            case (r_phase)
                PH_MAGIC: begin
                    if (r_cnt == WORD_END && w_sh != MAGIC_WORD) begin
                        o_rec.tail = TL_ERROR;
                        o_rec.code = ERR_MAGIC;
                    end
                end
                PH_TYPE: begin
                    if (r_cnt == WORD_END &&
                        !(w_sh[7:0] inside {TYPE_4BPP, TYPE_8BPP, TYPE_15BPP})) begin
                        o_rec.tail = TL_ERROR;
                        o_rec.code = ERR_TYPE;
                    end
                end
                PH_PALHDR: begin
                    w_defer = (r_cnt == HDR_HI_END);
                end
                PH_PALDATA: begin
                    if (r_cnt[0]) begin
                        o_rec.op   = OP_PAL;
                        o_rec.data = {i_byte, r_low};
                        o_rec.x    = r_ent_ctr[11:0];
                        o_rec.y    = r_set_ctr;
                    end
                end
                PH_PIXHDR: begin
                    if (r_cnt == HDR_HI_END && (r_row_width == '0 || w_rc_new == '0)) begin
                        o_rec.tail = TL_DONE;
                    end
                end
                PH_PIXDATA: begin
                    if (w_type4) begin
                        o_rec.op = w_nib2 ? OP_NIB2 : OP_NIB1;
                    end else if (w_type8) begin
                        o_rec.op = OP_IDX8;
                    end else if (r_cnt[0]) begin
                        o_rec.op   = OP_COLOR;
                        o_rec.data = {i_byte, r_low};
                    end
                    if (w_pix_emit && w_img_end) begin
                        o_rec.tail = TL_DONE;
                    end
                end
                default: ;
            endcase
        end
        if (w_step && w_eos && !w_defer && o_rec.tail == TL_NONE && r_phase != PH_IDLE) begin
            o_rec.tail = TL_ERROR;
            o_rec.code = ERR_TRUNC;
        end
        o_push = w_step && !w_defer && (rec_count(o_rec) != 2'd0 || r_held_pend);
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_type      = r_type;
        n_ent       = r_ent;
        n_sets      = r_sets;
        n_ent_ctr   = r_ent_ctr;
        n_set_ctr   = r_set_ctr;
        n_skip      = r_skip;
        n_row_width = r_row_width;
        n_row_count = r_row_count;
        n_col       = r_col;
        n_row       = r_row;
        n_low       = r_low;
        n_prod      = r_prod;
        n_eos_hold  = r_eos_hold;
        n_held_pend = o_push ? (rec_count(o_rec) == 2'd3) : r_held_pend;

        if (w_step) begin
            case (r_phase)
                PH_MAGIC: begin
                    n_shift = w_sh;
                    n_cnt   = r_cnt + 4'd1;
                    if (r_cnt == WORD_END) begin
                        if (w_sh != MAGIC_WORD) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_TYPE;
                            n_cnt   = '0;
                            n_shift = '0;
                        end
                    end
                end
                PH_TYPE: begin
                    n_shift = w_sh;
                    n_cnt   = r_cnt + 4'd1;
                    if (r_cnt == WORD_END) begin
                        n_type  = w_sh[7:0];
                        n_cnt   = '0;
                        n_shift = '0;
                        if (w_sh[7:0] inside {TYPE_4BPP, TYPE_8BPP}) begin
                            n_phase = PH_PALHDR;
                        end else if (w_sh[7:0] == TYPE_15BPP) begin
                            n_phase = PH_PIXHDR;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_PALHDR: begin
                    n_shift = w_sh;
                    n_cnt   = r_cnt + 4'd1;
                    case (r_cnt)
                        WORD_END: begin
                            n_skip  = w_sh;
                            n_shift = '0;
                        end
                        HDR_RSV_END: n_shift = '0;
                        HDR_LO_END:  n_ent   = w_sh[15:0];
                        HDR_HI_END: begin
                            n_sets     = w_sh[31:16];
                            n_prod     = r_ent * w_sh[31:16];
                            n_eos_hold = i_eos;
                            n_phase    = PH_PALCHK;
                        end
                        default: ;
                    endcase
                end
                PH_PALCHK: begin
                    if (w_over) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_skip    = w_skip_left;
                        n_ent_ctr = '0;
                        n_set_ctr = '0;
                        n_cnt     = '0;
                        n_shift   = '0;
                        if (r_ent == '0 || r_sets == '0) begin
                            n_phase = (w_skip_left != '0) ? PH_PALSKIP : PH_PIXHDR;
                        end else begin
                            n_phase = PH_PALDATA;
                        end
                    end
                end
                PH_PALDATA: begin
                    if (!r_cnt[0]) begin
                        n_low = i_byte;
                        n_cnt = 4'd1;
                    end else begin
                        n_cnt     = '0;
                        n_ent_ctr = w_ent_inc[15:0];
                        if (w_ent_inc >= {1'b0, r_ent}) begin
                            n_ent_ctr = '0;
                            n_set_ctr = w_set_inc[15:0];
                            if (w_set_inc >= {1'b0, r_sets}) begin
                                n_phase = (r_skip != '0) ? PH_PALSKIP : PH_PIXHDR;
                                n_shift = '0;
                            end
                        end
                    end
                end
                PH_PALSKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_phase = PH_PIXHDR;
                        n_cnt   = '0;
                        n_shift = '0;
                    end
                end
                PH_PIXHDR: begin
                    n_shift = w_sh;
                    n_cnt   = r_cnt + 4'd1;
                    case (r_cnt)
                        WORD_END, HDR_RSV_END: n_shift = '0;
                        HDR_LO_END: n_row_width = w_rw_new;
                        HDR_HI_END: begin
                            n_row_count = w_rc_new;
                            n_col       = '0;
                            n_row       = '0;
                            n_cnt       = '0;
                            n_shift     = '0;
                            n_phase     = (r_row_width == '0 || w_rc_new == '0) ?
                                          PH_IDLE : PH_PIXDATA;
                        end
                        default: ;
                    endcase
                end
                PH_PIXDATA: begin
                    if (!w_type4 && !w_type8) begin
                        n_cnt = r_cnt[0] ? 4'd0 : 4'd1;
                        if (!r_cnt[0]) begin
                            n_low = i_byte;
                        end
                    end
                    if (w_pix_emit) begin
                        if (w_wrap) begin
                            n_col = '0;
                            n_row = w_row_new;
                            if (w_img_end) begin
                                n_phase = PH_IDLE;
                            end
                        end else begin
                            n_col = w_col_new[11:0];
                        end
                    end
                end
                default: ;
            endcase

            if (w_eos && !w_defer) begin
                n_phase     = PH_MAGIC;
                n_cnt       = '0;
                n_shift     = '0;
                n_type      = '0;
                n_ent       = '0;
                n_sets      = '0;
                n_ent_ctr   = '0;
                n_set_ctr   = '0;
                n_skip      = '0;
                n_row_width = '0;
                n_row_count = '0;
                n_col       = '0;
                n_row       = '0;
                n_low       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_cnt       <= '0;
            r_shift     <= '0;
            r_type      <= '0;
            r_ent       <= '0;
            r_sets      <= '0;
            r_ent_ctr   <= '0;
            r_set_ctr   <= '0;
            r_skip      <= '0;
            r_row_width <= '0;
            r_row_count <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_low       <= '0;
            r_prod      <= '0;
            r_eos_hold  <= 1'b0;
            r_held_pend <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_type      <= n_type;
            r_ent       <= n_ent;
            r_sets      <= n_sets;
            r_ent_ctr   <= n_ent_ctr;
            r_set_ctr   <= n_set_ctr;
            r_skip      <= n_skip;
            r_row_width <= n_row_width;
            r_row_count <= n_row_count;
            r_col       <= n_col;
            r_row       <= n_row;
            r_low       <= n_low;
            r_prod      <= n_prod;
            r_eos_hold  <= n_eos_hold;
            r_held_pend <= n_held_pend;
        end
    end

endmodule

### sv/timdec_fifo.sv
// ============================================================================
// timdec_fifo: record queue
// Short register queue between the parser and the result generator.
// ============================================================================
module timdec_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  timdec_pkg::t_rec  i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output timdec_pkg::t_rec  o_rec
);
    import timdec_pkg::*;

    t_rec                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, n_wp;
    logic [FIFO_AW-1:0]  r_rp, n_rp;
    logic [FIFO_AW:0]    r_count, n_count;

    always_comb begin
        o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
        o_empty = (r_count == '0);
        o_rec   = r_mem[r_rp];
        n_wp    = i_push ? r_wp + 1'b1 : r_wp;
        n_rp    = i_pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

### sv/timdec_back.sv
// ============================================================================
// timdec_back: result generator
// Expands queued records into results, at most two per byte with the
// overflow result held for the next byte, through a registered output.
// ============================================================================
module timdec_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  timdec_pkg::t_rec     i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output timdec_pkg::t_result  o_res,
    output logic                 o_last
);
    import timdec_pkg::*;

    logic     r_out_valid, n_out_valid;
    t_result  r_out, n_out;
    logic     r_last, n_last;
    logic     r_idx, n_idx;
    logic     r_held_valid, n_held_valid;
    t_result  r_held, n_held;

    t_result     w_main0, w_main1, w_tail;
    t_result     w_r0, w_r1, w_r2;
    t_result     w_l0, w_l1, w_l2;
    logic [1:0]  w_mn, w_rn;
    logic [2:0]  w_n;
    logic [1:0]  w_e;
    logic        w_load, w_is_last;

    always_comb begin
        w_main0 = '{kind: K_INDEX, value: {12'b0, i_rec.data[3:0]},
                    x: i_rec.x, y: i_rec.y, code: CODE_NONE};
        w_main1 = '{kind: K_INDEX, value: {12'b0, i_rec.data[7:4]},
                    x: i_rec.x + 12'd1, y: i_rec.y, code: CODE_NONE};
        w_mn    = 2'd1;
        case (i_rec.op)
            OP_PAL: begin
                w_main0.kind  = K_PAL;
                w_main0.value = abgr_to_rgba(i_rec.data);
            end
            OP_NIB1: ;
            OP_NIB2: w_mn = 2'd2;
            OP_IDX8: w_main0.value = {8'b0, i_rec.data[7:0]};
            OP_COLOR: begin
                w_main0.kind  = K_COLOR;
                w_main0.value = abgr_to_rgba(i_rec.data);
            end
            default: w_mn = 2'd0;
        endcase
        w_tail = '{kind: (i_rec.tail == TL_DONE) ? K_DONE : K_ERROR,
                   value: '0, x: '0, y: '0, code: i_rec.code};
        w_rn = rec_count(i_rec);
        w_r0 = (w_mn != 2'd0) ? w_main0 : w_tail;
        w_r1 = (w_mn == 2'd2) ? w_main1 : w_tail;
        w_r2 = w_tail;

        // a held result goes ahead of this byte's own results
        if (r_held_valid) begin
            w_l0 = r_held;
            w_l1 = w_r0;
            w_l2 = w_r1;
        end else begin
            w_l0 = w_r0;
            w_l1 = w_r1;
            w_l2 = w_r2;
        end
        w_n = {1'b0, w_rn} + {2'b00, r_held_valid};
        w_e = (w_n > 3'd2) ? 2'd2 : w_n[1:0];
        w_is_last = ({1'b0, r_idx} == w_e - 2'd1);
        w_load = !i_empty && (!r_out_valid || i_ready);
    end

    always_comb begin
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        n_last       = r_last;
        n_idx        = r_idx;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        o_pop        = 1'b0;
        if (w_load) begin
            if (w_e == 2'd0) begin
                o_pop = 1'b1;
            end else begin
                n_out_valid = 1'b1;
                n_out       = r_idx ? w_l1 : w_l0;
                n_last      = w_is_last;
                if (w_is_last) begin
                    o_pop        = 1'b1;
                    n_idx        = 1'b0;
                    n_held_valid = (w_n == 3'd3);
                    n_held       = w_l2;
                end else begin
                    n_idx = 1'b1;
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_last <= n_last;
        r_held <= n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_idx        <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

### sv/tim_image_stream_decoder.sv
// Decodes a TIM image file streamed in one byte per transaction and emits
// palette entries, pixel indices or RGBA5551 pixels, plus error and done
// markers. The parser takes one byte per cycle while its four-entry record
// queue has room; the result side hands out one result per cycle while the
// result channel is ready, so bytes of 4-bit images (two pixels each) go
// slower than the rest, which sustain one per cycle. After the last byte of
// a palette header input pauses while the palette length is checked against
// the entry total from the multiplier. No clearing pass follows reset.
// ============================================================================
// tim_image_stream_decoder: TIM image stream decoder top level
// Configuration registers, parser, record queue and result generator.
// ============================================================================
module tim_image_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_value
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [15:0] value, [27:16] pos_x, [43:28] pos_y,
                                     // [45:44] error_code, [47:46] zero
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    import timdec_pkg::*;

    logic [11:0] r_forced_width;
    logic [8:0]  r_forced_height;

    logic    w_push, w_full, w_pop, w_empty;
    t_rec    w_rec_in, w_rec_out;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forced_width  <= '0;
            r_forced_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FORCED_WIDTH:  r_forced_width  <= i_cfg_data;
                CFG_FORCED_HEIGHT: r_forced_height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    timdec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_tvalid),
        .o_ready         (o_s_tready),
        .i_byte          (i_s_tdata),
        .i_eos           (i_s_tlast),
        .i_forced_width  (r_forced_width),
        .i_forced_height (r_forced_height),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_rec           (w_rec_in)
    );

    timdec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_rec   (w_rec_out)
    );

    timdec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_rec   (w_rec_out),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_res),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_res.code, w_res.y, w_res.x, w_res.value};
    assign o_m_tuser = w_res.kind;

endmodule

### sv/timdec_checker.sv
// ============================================================================
// timdec_checker: port-level checks for the TIM image stream decoder
// Watches the result channel and is bound to the top level.
// ============================================================================
module timdec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] o_m_tdata,
    input  logic [2:0]  o_m_tuser,
    input  logic        o_m_tlast
);
    import timdec_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_marker_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == K_ERROR || o_m_tuser == K_DONE) |->
        o_m_tdata[43:0] == '0)
        else $error("error or done result carries payload");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != K_ERROR |-> o_m_tdata[45:44] == CODE_NONE)
        else $error("error code on non-error result");

    a_index_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == K_INDEX |-> o_m_tdata[15:8] == '0)
        else $error("index pixel wider than 8 bits");

endmodule

bind tim_image_stream_decoder timdec_checker u_timdec_checker (.*);

### dv/tb_tim_image_stream_decoder.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_tim_image_stream_decoder: self-checking bench for the TIM stream decoder
// Streams TIM files byte by byte, predicts every result and compares each
// output transaction in order. Well-formed files of all three types dominate.
// Broken files cover bad magic, bad type, short palette blocks and truncation.
// Both sides stall in random bursts, except in the last phase, while several width/height overrides run.
// ============================================================================
module tb_tim_image_stream_decoder;
    import timdec_pkg::*;

    localparam int SETTLE      = 12;
    localparam int PHASE_BYTES = 250;
    localparam int N_PHASES    = 7;

    typedef struct {
        t_kind       kind;
        logic [15:0] value;
        logic [11:0] pos_x;
        logic [15:0] pos_y;
        logic [1:0]  code;
        logic        last;
    } t_tim_result;

    class tim_scoreboard;
        logic [11:0] forced_w;
        logic [8:0]  forced_h;
        t_phase      phase;
        logic [3:0]  fcnt;
        logic [31:0] fshift;
        logic [7:0]  img_type;
        logic [15:0] pal_len;
        logic [15:0] pal_sets;
        logic [15:0] entry_idx;
        logic [15:0] set_idx;
        logic [31:0] skip_left;
        logic [11:0] row_w;
        logic [15:0] row_n;
        logic [11:0] col;
        logic [15:0] row;
        logic [7:0]  lo_byte;
        bit          held_ok;
        t_tim_result held;
        t_tim_result step_q[$];
        t_tim_result pending_q[$];
        int          n_errors;
        int          kind_cnt[5];

        function new();
            forced_w = '0;
            forced_h = '0;
            held_ok  = 1'b0;
            n_errors = 0;
            foreach (kind_cnt[i]) kind_cnt[i] = 0;
            restart_file();
        endfunction

        function void set_reg(logic idx, logic [11:0] data);
            if (idx == CFG_FORCED_WIDTH) forced_w = data;
            else forced_h = data[8:0];
        endfunction

        function void restart_file();
            phase     = PH_MAGIC;
            fcnt      = '0;
            fshift    = '0;
            img_type  = '0;
            pal_len   = '0;
            pal_sets  = '0;
            entry_idx = '0;
            set_idx   = '0;
            skip_left = '0;
            row_w     = '0;
            row_n     = '0;
            col       = '0;
            row       = '0;
            lo_byte   = '0;
        endfunction

        function void open_field(t_phase next);
            phase  = next;
            fcnt   = '0;
            fshift = '0;
        endfunction

        function void leave_palette();
            if (skip_left != 0) open_field(PH_PALSKIP);
            else open_field(PH_PIXHDR);
        endfunction

        function void add(t_kind kind, logic [15:0] value, logic [11:0] x, logic [15:0] y,
                          logic [1:0] code);
            t_tim_result r;
            r.kind  = kind;
            r.value = value;
            r.pos_x = x;
            r.pos_y = y;
            r.code  = code;
            r.last  = 1'b0;
            step_q.push_back(r);
        endfunction

        // ABGR1555 in, RGBA5551 out; black keeps its stp bit, any color is opaque
        function logic [15:0] to_rgba5551(logic [15:0] c);
            logic [4:0] red, green, blue;
            logic       alpha;
            red   = c[4:0];
            green = c[9:5];
            blue  = c[14:10];
            alpha = ((red | green | blue) != 0) ? 1'b1 : c[15];
            return {red, green, blue, alpha};
        endfunction

        function void advance_pixel();
            col = col + 12'd1;
            if (col >= row_w) begin
                col = '0;
                row = row + 16'd1;
                if (row >= row_n) begin
                    phase = PH_IDLE;
                    add(K_DONE, '0, '0, '0, CODE_NONE);
                end
            end
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            logic [3:0]  cnt;
            logic [17:0] wide_w;
            logic [33:0] need;
            t_tim_result r;
            step_q = {};
            if (held_ok) begin
                step_q.push_back(held);
                held_ok = 1'b0;
            end
            cnt = fcnt;
            if (phase inside {PH_MAGIC, PH_TYPE, PH_PALHDR, PH_PIXHDR})
                fshift = fshift | (32'(b) << (8 * cnt[1:0]));
            case (phase)
                PH_MAGIC: begin
                    if (cnt == WORD_END) begin
                        if (fshift != MAGIC_WORD) begin
                            add(K_ERROR, '0, '0, '0, ERR_MAGIC);
                            phase = PH_IDLE;
                        end else begin
                            open_field(PH_TYPE);
                        end
                    end else begin
                        fcnt = cnt + 4'd1;
                    end
                end
                PH_TYPE: begin
                    if (cnt == WORD_END) begin
                        img_type = fshift[7:0];
                        if (img_type == TYPE_4BPP || img_type == TYPE_8BPP) begin
                            open_field(PH_PALHDR);
                        end else if (img_type == TYPE_15BPP) begin
                            open_field(PH_PIXHDR);
                        end else begin
                            add(K_ERROR, '0, '0, '0, ERR_TYPE);
                            phase = PH_IDLE;
                        end
                    end else begin
                        fcnt = cnt + 4'd1;
                    end
                end
                PH_PALHDR: begin
                    if (cnt == HDR_HI_END) begin
                        pal_sets = fshift[31:16];
                        need = PAL_HDR_BYTES + 34'(pal_len) * 34'(pal_sets) * 2;
                        if (need > {2'b00, skip_left}) begin
                            add(K_ERROR, '0, '0, '0, ERR_OVERRUN);
                            phase = PH_IDLE;
                        end else begin
                            skip_left = skip_left - need[31:0];
                            entry_idx = '0;
                            set_idx   = '0;
                            if (pal_len == 0 || pal_sets == 0) leave_palette();
                            else open_field(PH_PALDATA);
                        end
                    end else begin
                        if (cnt == WORD_END) begin
                            skip_left = fshift;
                            fshift    = '0;
                        end else if (cnt == HDR_RSV_END) begin
                            fshift = '0;
                        end else if (cnt == HDR_LO_END) begin
                            pal_len = fshift[15:0];
                        end
                        fcnt = cnt + 4'd1;
                    end
                end
                PH_PALDATA: begin
                    if (!cnt[0]) begin
                        lo_byte = b;
                        fcnt    = 4'd1;
                    end else begin
                        fcnt = '0;
                        add(K_PAL, to_rgba5551({b, lo_byte}), entry_idx[11:0], set_idx,
                            CODE_NONE);
                        entry_idx = entry_idx + 16'd1;
                        if (entry_idx >= pal_len) begin
                            entry_idx = '0;
                            set_idx   = set_idx + 16'd1;
                            if (set_idx >= pal_sets) leave_palette();
                        end
                    end
                end
                PH_PALSKIP: begin
                    skip_left = skip_left - 32'd1;
                    if (skip_left == 0) open_field(PH_PIXHDR);
                end
                PH_PIXHDR: begin
                    if (cnt == HDR_HI_END) begin
                        row_n = fshift[31:16];
                        if (forced_h != 0) row_n = 16'(forced_h);
                        col = '0;
                        row = '0;
                        open_field(PH_PIXDATA);
                        if (row_w == 0 || row_n == 0) begin
                            phase = PH_IDLE;
                            add(K_DONE, '0, '0, '0, CODE_NONE);
                        end
                    end else begin
                        if (cnt == HDR_LO_END) begin
                            wide_w = 18'(fshift[15:0]);
                            if (img_type == TYPE_4BPP) wide_w = 18'(wide_w * 4);
                            else if (img_type == TYPE_8BPP) wide_w = 18'(wide_w * 2);
                            row_w = (wide_w > 18'(MAX_ROW_WIDTH)) ? MAX_ROW_WIDTH :
                                    wide_w[11:0];
                            if (forced_w != 0) row_w = forced_w;
                        end else if (cnt == WORD_END || cnt == HDR_RSV_END) begin
                            fshift = '0;
                        end
                        fcnt = cnt + 4'd1;
                    end
                end
                PH_PIXDATA: begin
                    if (img_type == TYPE_4BPP) begin
                        add(K_INDEX, 16'(b[3:0]), col, row, CODE_NONE);
                        if (col + 12'd1 >= row_w) begin
                            advance_pixel();
                        end else begin
                            col = col + 12'd1;
                            add(K_INDEX, 16'(b[7:4]), col, row, CODE_NONE);
                            advance_pixel();
                        end
                    end else if (img_type == TYPE_8BPP) begin
                        add(K_INDEX, 16'(b), col, row, CODE_NONE);
                        advance_pixel();
                    end else if (!cnt[0]) begin
                        lo_byte = b;
                        fcnt    = 4'd1;
                    end else begin
                        fcnt = '0;
                        add(K_COLOR, to_rgba5551({b, lo_byte}), col, row, CODE_NONE);
                        advance_pixel();
                    end
                end
                default: ;
            endcase
            if (eos) begin
                if (phase != PH_IDLE) add(K_ERROR, '0, '0, '0, ERR_TRUNC);
                restart_file();
            end
            // at most two results per byte; a third waits for the next byte
            if (step_q.size() > 2) begin
                held    = step_q[2];
                held_ok = 1'b1;
            end
            for (int k = 0; k < step_q.size() && k < 2; k++) begin
                r      = step_q[k];
                r.last = (k == 1 || k == step_q.size() - 1);
                pending_q.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(t_tim_result got);
            t_tim_result want;
            if (pending_q.size() == 0) begin
                $error("unexpected result: kind %0d value %0h", got.kind, got.value);
                n_errors++;
                return;
            end
            want = pending_q.pop_front();
            kind_cnt[want.kind]++;
            compare_field("kind", 16'(want.kind), 16'(got.kind));
            compare_field("value", want.value, got.value);
            compare_field("pos_x", 16'(want.pos_x), 16'(got.pos_x));
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("error_code", 16'(want.code), 16'(got.code));
            compare_field("last_of_run", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [11:0] i_cfg_data;

    tim_scoreboard tracker = new();
    t_tim_result   mon_result;
    logic [7:0]    file_bytes[$];
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            bytes_sent = 0;
    int            files_sent = 0;

    tim_image_stream_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tim_image_stream_decoder: mismatch");
        $finish;
    end

    // result side back-pressure
    initial begin
        i_m_tready <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            mon_result.kind  = t_kind'(o_m_tuser);
            mon_result.value = o_m_tdata[15:0];
            mon_result.pos_x = o_m_tdata[27:16];
            mon_result.pos_y = o_m_tdata[43:28];
            mon_result.code  = o_m_tdata[45:44];
            mon_result.last  = o_m_tlast;
            tracker.check_result(mon_result);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        forever begin
            @(posedge i_clk);
            if (o_s_tready) break;
        end
        tracker.note_byte(b, eos);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_reg(idx, data);
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    function automatic logic [15:0] rand_color();
        logic [15:0] c;
        c = 16'($urandom);
        if ($urandom_range(0, 3) == 0) c = c & 16'h8000;
        return c;
    endfunction

    task automatic build_file(input logic [11:0] fw, input logic [8:0] fh);
        int unsigned     sel;
        int unsigned     n_ent;
        int unsigned     n_set;
        int unsigned     extra;
        int unsigned     rows;
        int unsigned     row_bytes;
        longint unsigned data_len;
        logic [7:0]      ty;
        logic [31:0]     word;
        logic [15:0]     hw;
        logic [15:0]     hh;
        logic [17:0]     px_w;
        bit              cut;
        bit              wild;
        file_bytes = {};
        sel  = $urandom_range(0, 99);
        wild = (sel >= 10 && sel < 14);
        cut  = wild || (sel >= 18 && sel < 26);
        word = MAGIC_WORD;
        if (sel < 4) begin
            word = $urandom;
            if (word == MAGIC_WORD) word = ~word;
        end
        push_le(word, 4);
        case ($urandom_range(0, 2))
            0:       ty = TYPE_4BPP;
            1:       ty = TYPE_8BPP;
            default: ty = TYPE_15BPP;
        endcase
        if (sel >= 4 && sel < 10) begin
            ty = (sel == 4) ? 8'h03 : 8'($urandom);
            while (ty == TYPE_4BPP || ty == TYPE_8BPP || ty == TYPE_15BPP) ty = 8'($urandom);
        end
        word = $urandom;
        if ($urandom_range(0, 1) == 0) word[31:8] = '0;
        word[7:0] = ty;
        push_le(word, 4);
        if (sel < 10) begin
            repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom));
        end else begin
            if (ty != TYPE_15BPP) begin
                extra = 0;
                if (wild) begin
                    n_ent = $urandom_range(0, 65535);
                    n_set = $urandom_range(0, 65535);
                    word  = $urandom;
                end else begin
                    n_ent = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                    n_set = $urandom_range(0, 2);
                    extra = $urandom_range(0, 5);
                    word  = 12 + 2 * n_ent * n_set + extra;
                    if (sel < 18) word = $urandom_range(0, 11 + 2 * n_ent * n_set);
                end
                push_le(word, 4);
                push_le($urandom, 4);
                push_le(n_ent, 2);
                push_le(n_set, 2);
                repeat ((n_ent * n_set > 24) ? 24 : n_ent * n_set) push_le(rand_color(), 2);
                repeat (extra) file_bytes.push_back(8'($urandom));
            end
            push_le($urandom, 4);
            push_le($urandom, 4);
            if (fw != 0 || wild) hw = 16'($urandom);
            else hw = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
            if (fh != 0 || wild) hh = 16'($urandom);
            else hh = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            push_le(hw, 2);
            push_le(hh, 2);
            px_w = 18'(18'(hw) * ((ty == TYPE_4BPP) ? 4 : (ty == TYPE_8BPP) ? 2 : 1));
            if (px_w > 18'd4095) px_w = 18'd4095;
            if (fw != 0) px_w = 18'(fw);
            rows = (fh != 0) ? fh : hh;
            if (ty == TYPE_4BPP) row_bytes = (px_w + 1) / 2;
            else if (ty == TYPE_8BPP) row_bytes = px_w;
            else row_bytes = 2 * px_w;
            data_len = longint'(rows) * row_bytes;
            if (data_len > 160) begin
                cut      = 1'b1;
                data_len = 160;
            end
            if (ty == TYPE_15BPP) repeat (data_len / 2) push_le(rand_color(), 2);
            else repeat (data_len) file_bytes.push_back(8'($urandom));
        end
        if (!cut) repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom));
        if (cut && file_bytes.size() > 1)
            file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 2)];
    endtask

    initial begin
        logic [11:0] fw_list[N_PHASES];
        logic [11:0] fh_list[N_PHASES];
        int          phase_start;
        int          files_in_phase;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_FORCED_WIDTH;
        i_cfg_data <= '0;
        fw_list = '{12'd0, 12'd4095, 12'd3, 12'd0, 12'd1, 12'd0, 12'd0};
        fh_list = '{12'd0, 12'd511, 12'd2, 12'd5, 12'd0, 12'd0, 12'd0};
        fw_list[5] = 12'($urandom_range(1, 24));
        fh_list[5] = {3'($urandom), 9'($urandom_range(1, 6))};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // lone end-of-stream byte, all-ones magic, 24-bit type
        file_bytes = '{8'h10};
        send_file();
        file_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file();
        file_bytes = '{8'h10, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00};
        send_file();

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == N_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            write_reg(CFG_FORCED_WIDTH, fw_list[p]);
            write_reg(CFG_FORCED_HEIGHT, fh_list[p]);
            phase_start    = bytes_sent;
            files_in_phase = 0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_file(tracker.forced_w, tracker.forced_h);
                send_file();
                files_in_phase++;
                if (files_in_phase == 3) drain();
            end
        end
        // flush a result still held back by the last byte
        if (tracker.held_ok) begin
            file_bytes = '{8'h00};
            send_file();
        end
        drain();

        $display("covered %0d files, %0d bytes, 7 width/height settings", files_sent, bytes_sent);
        $display("results: %0d palette, %0d index, %0d color, %0d error, %0d done",
                 tracker.kind_cnt[K_PAL], tracker.kind_cnt[K_INDEX], tracker.kind_cnt[K_COLOR],
                 tracker.kind_cnt[K_ERROR], tracker.kind_cnt[K_DONE]);
        if (tracker.n_errors == 0) begin
            $display("tim_image_stream_decoder: match");
        end else begin
            $display("tim_image_stream_decoder: mismatch");
        end
        $finish;
    end

endmodule

### tim_image_stream_decoder.f
sv/timdec_pkg.sv
sv/timdec_front.sv
sv/timdec_fifo.sv
sv/timdec_back.sv
sv/tim_image_stream_decoder.sv
sv/timdec_checker.sv
dv/tb_tim_image_stream_decoder.sv
